>>> hw/rtl/scf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scf_pkg: shared types and constants of the speech command framer
// Item structs, frame byte codes, emit step codes and the header byte lookup.
// ----------------------------------------------------------------------------
package scf_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 189;

    // Frame byte codes
    localparam logic [7:0] FRAME_START = 8'h7E;
    localparam logic [7:0] FRAME_ZERO  = 8'h00;
    localparam logic [7:0] FRAME_CMD   = 8'h01;
    localparam logic [7:0] FRAME_PARAM = 8'h03;
    localparam logic [7:0] FRAME_CODE  = 8'hE8;
    localparam logic [7:0] FRAME_END   = 8'hEF;
    localparam logic [7:0] LEN_OFFSET  = 8'd9;

    // Sum of the fixed summed header bytes (second byte through E8), length terms excluded
    localparam logic [7:0] HDR_SUM = 8'(FRAME_ZERO + LEN_OFFSET + FRAME_CMD + FRAME_ZERO
                                        + FRAME_PARAM + FRAME_PARAM + FRAME_CODE);

    // Emit step: position of a byte within a whole frame item
    typedef logic [3:0] step_t;

    localparam step_t STEP_SOF     = 4'd0;
    localparam step_t STEP_ZERO_A  = 4'd1;
    localparam step_t STEP_LEN9    = 4'd2;
    localparam step_t STEP_CMD     = 4'd3;
    localparam step_t STEP_ZERO_B  = 4'd4;
    localparam step_t STEP_PARAM_A = 4'd5;
    localparam step_t STEP_PARAM_B = 4'd6;
    localparam step_t STEP_CODE    = 4'd7;
    localparam step_t STEP_LEN     = 4'd8;
    localparam step_t STEP_DATA    = 4'd9;
    localparam step_t STEP_CHK     = 4'd10;
    localparam step_t STEP_EOF     = 4'd11;

    typedef struct packed {
        logic [7:0] payload_length;
        logic [7:0] payload_byte;
    } text_item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       run_last;
        logic       frame_end;
    } frame_item_t;

    // What one accepted item has to emit
    typedef struct packed {
        logic       is_start;
        logic       has_data;
        logic       closes;
        logic [7:0] len;
        logic [7:0] data;
        logic [7:0] chk;
    } item_desc_t;

    function automatic logic [7:0] frame_byte_at(
        input step_t      step,
        input logic [7:0] len,
        input logic [7:0] data,
        input logic [7:0] chk
    );
        logic [7:0] b;
        unique case (step)
            STEP_SOF:     b = FRAME_START;
            STEP_ZERO_A:  b = FRAME_ZERO;
            STEP_LEN9:    b = 8'(len + LEN_OFFSET);
            STEP_CMD:     b = FRAME_CMD;
            STEP_ZERO_B:  b = FRAME_ZERO;
            STEP_PARAM_A: b = FRAME_PARAM;
            STEP_PARAM_B: b = FRAME_PARAM;
            STEP_CODE:    b = FRAME_CODE;
            STEP_LEN:     b = len;
            STEP_DATA:    b = data;
            STEP_CHK:     b = chk;
            STEP_EOF:     b = FRAME_END;
            default:      b = FRAME_ZERO;
        endcase
        return b;
    endfunction

endpackage

>>> hw/rtl/speech_command_framer_top.sv
`timescale 1ns / 1ps
// Path: an item's bytes pass from the item register through the output register to frame.
// Throughput: one frame byte per cycle while frame_stall is low; a mid-frame item
// emits its data byte, a frame-start item the header and its data byte (an empty
// frame has none), and a closing item also the checksum and end marker.
// Reset: rst_n async low; no frame open, checksum and byte count cleared.
// ----------------------------------------------------------------------------
// speech_command_framer_top: speech-module command frame builder
// Wraps a byte stream into frames: header, payload, checksum, end marker.
// ----------------------------------------------------------------------------
module speech_command_framer_top
    import scf_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        text_valid,
    output logic        text_stall,
    input  text_item_t  text,
    output logic        frame_valid,
    input  logic        frame_stall,
    output frame_item_t frame
);

    // Frame state, updated as each item is accepted
    logic       in_frame_reg;
    logic       in_frame_next;
    logic [7:0] bytes_left_reg;
    logic [7:0] bytes_left_next;
    logic [7:0] running_sum_reg;
    logic [7:0] running_sum_next;

    logic       busy;
    logic       accept;
    logic [7:0] len_sat;
    logic [7:0] left_after;
    item_desc_t desc;

    assign text_stall = busy;
    assign accept     = text_valid && !busy;

    // Length is only sampled on a frame's first item and clamps to the max
    assign len_sat = (text.payload_length > 8'(MAX_PAYLOAD)) ? 8'(MAX_PAYLOAD)
                                                             : text.payload_length;

    // Build the item's descriptor. The checksum is fully known at accept:
    // header contributes HDR_SUM plus the length byte twice (len+9 and len),
    // then the data byte is added when present.
    always_comb
    begin
        desc       = '0;
        left_after = 8'd0;
        desc.data  = text.payload_byte;
        if (!in_frame_reg)
        begin
            desc.is_start = 1'b1;
            desc.len      = len_sat;
            desc.has_data = (len_sat != 8'd0);
            desc.chk      = 8'(HDR_SUM + len_sat + len_sat
                               + (desc.has_data ? text.payload_byte : 8'd0));
            left_after    = desc.has_data ? 8'(len_sat - 8'd1) : 8'd0;
        end
        else
        begin
            desc.is_start = 1'b0;
            desc.len      = 8'd0;
            desc.has_data = 1'b1;
            desc.chk      = 8'(running_sum_reg + text.payload_byte);
            // open frame with nothing left still closes after this byte
            left_after    = (bytes_left_reg != 8'd0) ? 8'(bytes_left_reg - 8'd1) : 8'd0;
        end
        desc.closes = (left_after == 8'd0);

        in_frame_next    = in_frame_reg;
        bytes_left_next  = bytes_left_reg;
        running_sum_next = running_sum_reg;
        if (accept)
        begin
            in_frame_next    = !desc.closes;
            bytes_left_next  = left_after;
            running_sum_next = desc.closes ? 8'd0 : desc.chk;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg    <= 1'b0;
            bytes_left_reg  <= 8'd0;
            running_sum_reg <= 8'd0;
        end
        else
        begin
            in_frame_reg    <= in_frame_next;
            bytes_left_reg  <= bytes_left_next;
            running_sum_reg <= running_sum_next;
        end
    end

    scf_emitter u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .desc        (desc),
        .busy        (busy),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame)
    );

`ifndef ASSERT_OFF
    a_open_has_left: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (bytes_left_reg != 8'd0))
        else $error("open frame with no bytes left");

    a_closed_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> (bytes_left_reg == 8'd0 && running_sum_reg == 8'd0))
        else $error("closed frame with stale count or sum");

    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_left_reg < 8'(MAX_PAYLOAD))
        else $error("bytes left exceeds max payload");
`endif

endmodule

>>> hw/rtl/scf_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scf_emitter: item register, step counter and output register
// Holds one item descriptor and walks its bytes out, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module scf_emitter
    import scf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  item_desc_t  desc,
    output logic        busy,
    output logic        frame_valid,
    input  logic        frame_stall,
    output frame_item_t frame
);

    logic        item_valid_reg;
    logic        item_valid_next;
    item_desc_t  item_reg;
    step_t       step_reg;
    step_t       step_next;
    step_t       last_step;
    logic        out_valid_reg;
    frame_item_t out_reg;
    logic        out_adv;
    logic        emitting;
    logic        item_done;

    assign out_adv   = !out_valid_reg || !frame_stall;
    assign emitting  = item_valid_reg && out_adv;
    assign last_step = item_reg.closes ? STEP_EOF : STEP_DATA;
    assign item_done = emitting && (step_reg == last_step);
    assign busy      = item_valid_reg && !item_done;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        step_next       = step_reg;
        if (load)
        begin
            item_valid_next = 1'b1;
            step_next       = desc.is_start ? STEP_SOF : STEP_DATA;
        end
        else if (emitting)
        begin
            if (item_done)
                item_valid_next = 1'b0;
            // zero-length frame has no data byte
            if (step_reg == STEP_LEN && !item_reg.has_data)
                step_next = STEP_CHK;
            else
                step_next = 4'(step_reg + 4'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            step_reg       <= STEP_SOF;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            step_reg       <= step_next;
            if (out_adv)
                out_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= desc;
        if (emitting)
        begin
            out_reg.frame_byte <= frame_byte_at(step_reg, item_reg.len,
                                                item_reg.data, item_reg.chk);
            out_reg.run_last   <= (step_reg == last_step);
            out_reg.frame_end  <= (step_reg == STEP_EOF);
        end
    end

    assign frame_valid = out_valid_reg;
    assign frame       = out_reg;

`ifndef ASSERT_OFF
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg |-> (step_reg <= last_step))
        else $error("step past last byte of item");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.frame_end) |-> out_reg.run_last)
        else $error("end marker not last byte of item");

    a_start_step: assert property (@(posedge clk) disable iff (!rst_n)
        (load && desc.is_start) |=> (step_reg == STEP_SOF))
        else $error("frame start item not at header start");

    a_no_data_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !item_reg.has_data) |-> (step_reg != STEP_DATA))
        else $error("empty frame emitting a data byte");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !busy)
        else $error("item loaded over a pending item");
`endif

endmodule

>>> tb/sv/speech_command_framer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// speech_command_framer_top_tb: self-checking bench for the command framer
// Sends whole text frames over the valid/stall input, predicts every frame
// byte with its own framing model, and compares each output item in order
// while both sides idle at random and the output side holds off once for long.
// ----------------------------------------------------------------------------
module speech_command_framer_top_tb;

    import scf_pkg::*;

    localparam int unsigned CLK_HALF      = 4;
    localparam int unsigned RESET_CYCLES  = 8;
    localparam int unsigned RANDOM_ITEMS  = 316;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned DRAIN_CYCLES  = 24;
    localparam int unsigned CYCLE_LIMIT   = 300000;

    // ------------------------------------------------------------------------
    // Frame scoreboard: tracks frame state, builds the expected frame bytes
    // for each accepted text item and checks output items against them.
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        bit          in_frame;
        logic [7:0]  bytes_left;
        logic [7:0]  running_sum;
        frame_item_t expected_bytes[$];
        int unsigned failures;

        function new();
            in_frame    = 1'b0;
            bytes_left  = '0;
            running_sum = '0;
            failures    = 0;
        endfunction

        function void push_byte(input logic [7:0] b, input bit is_end);
            frame_item_t f;
            f.frame_byte = b;
            f.run_last   = 1'b0;
            f.frame_end  = is_end;
            expected_bytes.push_back(f);
            running_sum = 8'(running_sum + b);
        endfunction

        // Checksum then end marker; frame state returns to idle
        function void close_frame();
            push_byte(running_sum, 1'b0);
            push_byte(FRAME_END, 1'b1);
            in_frame    = 1'b0;
            bytes_left  = '0;
            running_sum = '0;
        endfunction

        function void take_text(input text_item_t it);
            logic [7:0]  len;
            frame_item_t last;
            if (!in_frame)
            begin
                len = (it.payload_length > MAX_PAYLOAD_DEF) ? 8'(MAX_PAYLOAD_DEF)
                                                            : it.payload_length;
                push_byte(FRAME_START, 1'b0);
                running_sum = '0;   // start byte stays out of the checksum
                push_byte(FRAME_ZERO, 1'b0);
                push_byte(8'(len + LEN_OFFSET), 1'b0);
                push_byte(FRAME_CMD, 1'b0);
                push_byte(FRAME_ZERO, 1'b0);
                push_byte(FRAME_PARAM, 1'b0);
                push_byte(FRAME_PARAM, 1'b0);
                push_byte(FRAME_CODE, 1'b0);
                push_byte(len, 1'b0);
                if (len == 8'd0)
                begin
                    close_frame();
                end
                else
                begin
                    push_byte(it.payload_byte, 1'b0);
                    bytes_left = 8'(len - 8'd1);
                    if (bytes_left == 8'd0)
                        close_frame();
                    else
                        in_frame = 1'b1;
                end
            end
            else
            begin
                push_byte(it.payload_byte, 1'b0);
                if (bytes_left > 8'd0)
                    bytes_left = 8'(bytes_left - 8'd1);
                if (bytes_left == 8'd0)
                    close_frame();
            end
            last = expected_bytes.pop_back();
            last.run_last = 1'b1;
            expected_bytes.push_back(last);
        endfunction

        function void check_frame(input frame_item_t got);
            frame_item_t want;
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected frame item byte=%h last=%b end=%b",
                         $time, got.frame_byte, got.run_last, got.frame_end);
                failures++;
                return;
            end
            want = expected_bytes.pop_front();
            if (got.frame_byte !== want.frame_byte)
            begin
                $display("%0t: frame_byte expected %h actual %h",
                         $time, want.frame_byte, got.frame_byte);
                failures++;
            end
            if (got.run_last !== want.run_last)
            begin
                $display("%0t: run_last expected %b actual %b",
                         $time, want.run_last, got.run_last);
                failures++;
            end
            if (got.frame_end !== want.frame_end)
            begin
                $display("%0t: frame_end expected %b actual %b",
                         $time, want.frame_end, got.frame_end);
                failures++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    // Block pins; every input starts at a known value
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        text_valid  = 1'b0;
    logic        text_stall;
    text_item_t  text        = '0;
    logic        frame_valid;
    logic        frame_stall = 1'b0;
    frame_item_t frame;

    // Idle control shared between sender, receiver and the hold-off process
    logic        quiet   = 1'b0;   // no random idling on either side
    logic        hold_go = 1'b0;   // asks the hold-off process for one long receiver hold-off
    logic        hold_on = 1'b0;

    int unsigned     text_count = 0;
    int unsigned     cycles     = 0;
    frame_scoreboard sb         = new();

    speech_command_framer_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_stall  (text_stall),
        .text        (text),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Run limit, far above the slowest legal run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic text_item_t make_text(input logic [7:0] len, input logic [7:0] b);
        text_item_t t;
        t.payload_length = len;
        t.payload_byte   = b;
        return t;
    endfunction

    // Offer one item and wait for the edge that takes it. Signals are read
    // right after the edge, so they hold their pre-edge values. A random gap
    // drops valid first; otherwise valid stays high from item to item.
    task automatic send_text(input text_item_t it);
        if (!quiet && $urandom_range(0, 99) < 16)
        begin
            text_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        text_valid <= 1'b1;
        text       <= it;
        do
            @(posedge clk);
        while (text_stall);
        sb.take_text(it);
        text_count++;
    endtask

    // One well-formed frame: the first item carries the length, later items
    // carry random lengths that the block must ignore.
    task automatic send_frame(input logic [7:0] len);
        int unsigned items;
        items = (len == 8'd0) ? 1
              : ((len > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : int'(len));
        send_text(make_text(len, 8'($urandom_range(0, 255))));
        for (int i = 1; i < items; i++)
            send_text(make_text(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
    endtask

    // Receiver: check on each accepting edge, then pick the next stall value
    always @(posedge clk)
    begin
        if (rst_n && frame_valid && !frame_stall)
            sb.check_frame(frame);
        frame_stall <= hold_on || (!quiet && $urandom_range(0, 99) < 16);
    end

    // Long output hold-off, counted here, while the sender keeps offering
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    initial
    begin
        int unsigned random_start;
        int unsigned pick;
        bit          big_done;
        logic [7:0]  len;

        big_done = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty frames (data ignored), single-byte frames at both
        // byte extremes, ignored lengths on later items, checksum wrap.
        send_text(make_text(8'd0, 8'hFF));
        send_text(make_text(8'd0, 8'h00));
        send_text(make_text(8'd1, 8'h00));
        send_text(make_text(8'd1, 8'hFF));
        send_text(make_text(8'd2, 8'hFF));
        send_text(make_text(8'hFF, 8'h00));
        send_text(make_text(8'd4, 8'hFF));
        send_text(make_text(8'd0, 8'hFF));
        send_text(make_text(8'hAA, 8'hFF));
        send_text(make_text(8'h55, 8'hFF));
        send_text(make_text(8'd3, 8'hA5));
        send_text(make_text(8'd0, 8'h5A));
        send_text(make_text(8'd128, 8'h01));
        send_text(make_text(8'd0, 8'h80));

        // Random frames; mostly short, one saturating length, a quiet stretch
        random_start = text_count;
        hold_go <= 1'b1;
        while (text_count - random_start < RANDOM_ITEMS)
        begin
            quiet <= (text_count - random_start >= 60) && (text_count - random_start < 110);
            if (!big_done && text_count - random_start >= 115)
            begin
                send_frame(8'($urandom_range(MAX_PAYLOAD_DEF + 1, 255)));
                big_done = 1'b1;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    len = 8'd0;
                else if (pick < 85)
                    len = 8'($urandom_range(1, 8));
                else
                    len = 8'($urandom_range(9, 40));
                send_frame(len);
            end
        end

        // Drain: stop offering, wait for every expected byte, then let the
        // block settle so any stray item is still caught.
        text_valid <= 1'b0;
        quiet      <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
